// File: src/signed_integer_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// signed_integer_to_decimal_ascii_assert.svh
// Assertion macros shared by the decimal ASCII converter.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define SIDASC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define SIDASC_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SIDASC_ASSERT(label, clk, rst, prop, msg)
`define SIDASC_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// File: src/sidasc_pkg.sv
// ---------------------------------------------------------------------------
// sidasc_pkg
// Shared types, constants and helpers for the decimal ASCII converter.
// ---------------------------------------------------------------------------
package sidasc_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CHAR_BITS          = 6;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

   // decimal digits needed for the largest magnitude, 2^(bits-1);
   // 1233/4096 approximates log10(2) closely enough up to 64 bits
   function automatic int digit_count(input int bits);
      return (((bits - 1) * 1233) >> 12) + 1;
   endfunction

   typedef struct packed {
      logic busy;
      logic done;
   } conv_status_type;

   typedef struct packed {
      logic load;
      logic negative;
   } emit_cmd_type;

endpackage

// File: src/signed_integer_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_integer_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, MSD first, with a
// leading minus for negative values and no leading zeros.
// ---------------------------------------------------------------------------
//   channel   direction   ports                                    handshake
//   req       in          req_value                                req_valid / req_stall
//   rsp       out         rsp_character, rsp_last                  rsp_valid / rsp_stall
//
// One request at a time. With no output stalls the spacing from one request
// to the next is set by the bit-serial BCD shift and the digit shift-out (one
// digit per cycle), and a minus sign lengthens it.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled character holds in the output register; the next request is taken
// once the shift-out and then the control state go idle, even while it waits.
// ---------------------------------------------------------------------------
`include "signed_integer_to_decimal_ascii_assert.svh"

module signed_integer_to_decimal_ascii #(
   parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sidasc_pkg::CHAR_BITS-1:0]    rsp_character,
   output logic                                rsp_last
);

   localparam int DIGITS = sidasc_pkg::digit_count(VALUE_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic                          neg_ff, neg_in;
   logic                          accept;
   logic [VALUE_BITS-1:0]         magnitude;
   logic [4*DIGITS-1:0]           bcd;
   logic                          emit_active;
   sidasc_pkg::conv_status_type   conv_status;
   sidasc_pkg::emit_cmd_type      emit_cmd;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // unsigned magnitude: the most negative value maps to 2^(VALUE_BITS-1)
   assign magnitude = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;

   always_comb begin
      state_in          = state_ff;
      neg_in            = neg_ff;
      emit_cmd.load     = 1'b0;
      emit_cmd.negative = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in   = req_value[VALUE_BITS-1];
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_status.done) begin
               emit_cmd.load = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_active) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff <= neg_in;
   end

   sidasc_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (magnitude),
      .bcd       (bcd),
      .status    (conv_status)
   );

   sidasc_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .cmd           (emit_cmd),
      .bcd           (bcd),
      .active        (emit_active),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   `SIDASC_ASSERT(a_accept_starts, clock, reset, accept |=> conv_status.busy, "request taken but conversion not started")
   `SIDASC_NEVER(a_done_outside_conv, clock, reset, conv_status.done && state_ff != ST_CONV, "conversion finished outside convert state")
   `SIDASC_ASSERT(a_load_emits, clock, reset, emit_cmd.load |=> emit_active, "digits loaded but shift-out idle")

endmodule

// File: src/sidasc_dabble.sv
// ---------------------------------------------------------------------------
// sidasc_dabble
// Bit-serial binary to BCD conversion (shift and add three), one input bit
// per cycle, MSB first.
// ---------------------------------------------------------------------------
`include "signed_integer_to_decimal_ascii_assert.svh"

module sidasc_dabble #(
   parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEFAULT,
   parameter int DIGITS     = sidasc_pkg::digit_count(VALUE_BITS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_BITS-1:0]          magnitude,
   output logic [4*DIGITS-1:0]            bcd,
   output sidasc_pkg::conv_status_type    status
);

   localparam int CountBits = $clog2(VALUE_BITS + 1);
   localparam logic [CountBits-1:0] CountLoad = CountBits'(VALUE_BITS);
   localparam logic [CountBits-1:0] CountOne  = CountBits'(1);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [4*DIGITS-1:0]   bcd_ff, bcd_in;
   logic [4*DIGITS-1:0]   adjusted;
   logic [CountBits-1:0]  count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = magnitude;
         bcd_in   = '0;
         count_in = CountLoad;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bin_in   = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = {adjusted[4*DIGITS-2:0], bin_ff[VALUE_BITS-1]};
         count_in = count_ff - CountOne;
         if (count_ff == CountOne) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd         = bcd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `SIDASC_NEVER(a_done_while_busy, clock, reset, done_ff && busy_ff, "done raised while shifting")
   `SIDASC_ASSERT(a_busy_count, clock, reset, busy_ff |-> count_ff != '0, "shift count ran out while busy")

endmodule

// File: src/sidasc_emit.sv
// ---------------------------------------------------------------------------
// sidasc_emit
// Sends any minus sign, then shifts BCD digits out one per cycle when not
// stalled, MSD first, dropping leading zeros; drives the registered characters.
// ---------------------------------------------------------------------------
`include "signed_integer_to_decimal_ascii_assert.svh"

module sidasc_emit #(
   parameter int DIGITS = sidasc_pkg::digit_count(sidasc_pkg::VALUE_BITS_DEFAULT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sidasc_pkg::emit_cmd_type            cmd,
   input  logic [4*DIGITS-1:0]                 bcd,
   output logic                                active,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sidasc_pkg::CHAR_BITS-1:0]    rsp_character,
   output logic                                rsp_last
);

   localparam int LeftBits = $clog2(DIGITS + 1);
   localparam logic [LeftBits-1:0] LeftLoad = LeftBits'(DIGITS);
   localparam logic [LeftBits-1:0] LeftOne  = LeftBits'(1);

   logic [4*DIGITS-1:0]               digits_ff, digits_in;
   logic [LeftBits-1:0]               left_ff, left_in;
   logic                              sign_ff, sign_in;
   logic                              seen_ff, seen_in;
   logic                              active_ff, active_in;
   logic                              out_valid_ff, out_valid_in;
   logic [sidasc_pkg::CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                              out_last_ff, out_last_in;
   logic                              advance;
   logic [3:0]                        top_digit;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign top_digit = digits_ff[4*DIGITS-1 -: 4];

   always_comb begin
      digits_in    = digits_ff;
      left_in      = left_ff;
      sign_in      = sign_ff;
      seen_in      = seen_ff;
      active_in    = active_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      // drop the held character once taken
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.load) begin
         digits_in = bcd;
         left_in   = LeftLoad;
         sign_in   = cmd.negative;
         seen_in   = 1'b0;
         active_in = 1'b1;
      end else if (active_ff && advance) begin
         if (sign_ff) begin
            out_char_in  = sidasc_pkg::ASCII_MINUS;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
            sign_in      = 1'b0;
         end else begin
            digits_in = {digits_ff[4*DIGITS-5:0], 4'd0};
            left_in   = left_ff - LeftOne;
            // skip leading zeros, but always keep the units digit
            if (top_digit != 4'd0 || seen_ff || left_ff == LeftOne) begin
               out_char_in  = sidasc_pkg::ASCII_ZERO + {2'b00, top_digit};
               out_last_in  = (left_ff == LeftOne);
               out_valid_in = 1'b1;
               seen_in      = 1'b1;
            end
            if (left_ff == LeftOne) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         left_ff      <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         sign_ff      <= sign_in;
         seen_ff      <= seen_in;
         left_ff      <= left_in;
      end
      digits_ff   <= digits_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign active        = active_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;

   `SIDASC_NEVER(a_minus_last, clock, reset, out_valid_ff && out_last_ff && out_char_ff == sidasc_pkg::ASCII_MINUS, "minus sign flagged as last")
   `SIDASC_NEVER(a_load_busy, clock, reset, cmd.load && active_ff, "load while digits still pending")
   `SIDASC_ASSERT(a_sign_first, clock, reset, sign_ff |-> !seen_ff, "sign pending after a digit was sent")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed integer to decimal ASCII converter.
// A short table of directed values (zero, single digits, powers of ten, the
// largest and most negative integers) runs first. A random mix of full-range,
// small and boundary values follows. Every returned character and its last
// flag is compared in order against the directed text or, if that is empty, a
// bit-accurate predictor. Both handshakes idle at random, and the bench also
// forces a long output hold-off and a full drain partway through.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS      = 32;
   localparam int RANDOM_REQUESTS = 200;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_OFF_AT     = 60;
   localparam int PAUSE_AT        = 120;
   localparam int STEADY_FIRST    = 150;
   localparam int STEADY_LAST     = 180;
   localparam int N_DIRECTED      = 21;

   localparam logic [VALUE_BITS-1:0] POW10 [0:9] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
      32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
   };

   typedef struct packed {
      logic [sidasc_pkg::CHAR_BITS-1:0] character;
      logic                             last;
   } text_char_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [VALUE_BITS-1:0]            req_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [sidasc_pkg::CHAR_BITS-1:0] rsp_character;
   logic                             rsp_last;

   text_char_type pending_chars[$];
   text_char_type next_char;
   int         mismatch_count = 0;
   int         chars_checked  = 0;
   int         values_sent    = 0;
   int         negatives_sent = 0;
   int         cycle_count    = 0;
   bit         hold_off_req   = 0;
   bit         steady_flow    = 0;

   // empty text: expectation comes from the predictor
   logic [VALUE_BITS-1:0] directed_value [N_DIRECTED] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
      32'h0000_000A, 32'hFFFF_FFF7, 32'hFFFF_FFF6, 32'h0000_0064,
      32'h0000_FFFF, 32'hFFFF_0000, 32'h3B9A_C9FF, 32'h3B9A_CA00,
      32'hC465_3600, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
      32'hDEAD_BEEF
   };
   string directed_text [N_DIRECTED] = '{
      "0", "1", "-1", "9",
      "10", "-9", "-10", "100",
      "65535", "-65536", "999999999", "1000000000",
      "-1000000000", "2147483647", "-2147483648", "-2147483647",
      "", "", "", "",
      ""
   };

   signed_integer_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // decimal text of a two's complement value, most significant digit first
   function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] v);
      logic              negative;
      logic [VALUE_BITS:0] magnitude;
      logic [3:0]        digit [0:19];
      int                n;
      negative  = v[VALUE_BITS-1];
      // one extra bit keeps the most negative value exact
      magnitude = {v[VALUE_BITS-1], v};
      if (negative) begin
         magnitude = -magnitude;
      end
      n = 0;
      do begin
         digit[n]  = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         n++;
      end while (magnitude != 0);
      if (negative) begin
         pending_chars.push_back(text_char_type'{sidasc_pkg::ASCII_MINUS, 1'b0});
      end
      for (int i = n - 1; i >= 0; i--) begin
         pending_chars.push_back(text_char_type'{
            sidasc_pkg::ASCII_ZERO + sidasc_pkg::CHAR_BITS'(digit[i]), i == 0});
      end
   endfunction

   function automatic void queue_literal_text(input string s);
      byte c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         pending_chars.push_back(text_char_type'{c[sidasc_pkg::CHAR_BITS-1:0],
                                                 i == s.len() - 1});
      end
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_cycles();
      int roll;
      if (steady_flow) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(12, 50);
   endfunction

   task automatic send_value(input logic [VALUE_BITS-1:0] v, input string literal,
                             input bit drain);
      int gap;
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      values_sent++;
      if (v[VALUE_BITS-1]) begin
         negatives_sent++;
      end
      if (literal.len() != 0) begin
         queue_literal_text(literal);
      end else begin
         queue_decimal_text(v);
      end
      gap = idle_cycles();
      if (gap > 0 || drain) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain) begin
            do @(posedge clock); while (pending_chars.size() != 0);
         end
      end
   endtask

   // request stimulus
   initial begin
      logic [VALUE_BITS-1:0] v;
      int                    kind;
      int                    k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         send_value(directed_value[r], directed_text[r], 1'b0);
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == HOLD_OFF_AT) begin
            hold_off_req = 1'b1;
         end
         steady_flow = (n >= STEADY_FIRST && n < STEADY_LAST);
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               v = $urandom;
            end
            4, 5: begin
               v = $urandom_range(0, 99);
            end
            6, 7: begin
               k = $urandom_range(1, 9);
               v = $urandom_range(0, POW10[k] - 1);
            end
            8: begin
               k = $urandom_range(0, 9);
               v = POW10[k] - $urandom_range(0, 1);
            end
            default: begin
               if ($urandom_range(0, 1)) begin
                  v = 32'h7FFF_FFFF - $urandom_range(0, 15);
               end else begin
                  v = 32'h8000_0000 + $urandom_range(0, 15);
               end
            end
         endcase
         if (kind >= 4 && kind <= 8 && $urandom_range(0, 1)) begin
            v = '0 - v;
         end
         send_value(v, "", n == PAUSE_AT);
      end
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values (%0d directed, %0d negative), checked %0d characters",
               values_sent, N_DIRECTED, negatives_sent, chars_checked);
      $display("Output hold-off of %0d cycles and one full drain exercised, %0d mismatches",
               HOLD_OFF_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side stall pattern, with one long hold-off to back up the block
   initial begin
      int stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = idle_cycles();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character %0d last %0b", $time, rsp_character,
                     rsp_last);
            mismatch_count++;
         end else begin
            next_char = pending_chars.pop_front();
            chars_checked++;
            if (rsp_character !== next_char.character) begin
               $display("%0t: character expected %0d actual %0d", $time,
                        next_char.character, rsp_character);
               mismatch_count++;
            end
            if (rsp_last !== next_char.last) begin
               $display("%0t: last expected %0b actual %0b", $time, next_char.last,
                        rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d characters outstanding", $time,
                  cycle_count, pending_chars.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
